// ===== hdl/mfde_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_pkg
// Shared types and constants for the monochrome frame buffer draw engine.
// ----------------------------------------------------------------------------
package mfde_pkg;

   // coordinate fields on the request channel
   localparam int COORD_W = 9;
   // Q16 fraction of the line accumulator
   localparam int FRAC_W  = 16;
   // slope = floor(minor * 2^16 / major), at most 2^16
   localparam int SLOPE_W = FRAC_W + 1;
   // dividend of the slope division: minor shifted up by the fraction
   localparam int DIVN_W  = COORD_W + FRAC_W;
   // minor accumulator: start (9b) plus up to 511 steps of +-2^16
   localparam int ACC_W   = 28;
   // major coordinate: start plus up to 511 unit steps
   localparam int MAJ_W   = 11;
   // byte returned by a page read
   localparam int BYTE_W  = 8;

   typedef enum logic [2:0] {
      CMD_PIXEL = 3'd0,
      CMD_CLEAR = 3'd1,
      CMD_LINE  = 3'd2,
      CMD_FRAME = 3'd3,
      CMD_BAR   = 3'd4,
      CMD_READ  = 3'd5,
      CMD_NOP   = 3'd6,
      CMD_SPARE = 3'd7
   } cmd_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV,
      ST_LSTEP,
      ST_RD,
      ST_WR,
      ST_FIN
   } state_type;

endpackage
`default_nettype wire

// ===== hdl/mono_framebuffer_draw_engine.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mono_framebuffer_draw_engine
// One-bit frame store with pixel, clear, line, frame, bar and page read.
// ----------------------------------------------------------------------------
// The frame lives in a single-port column memory, one word per column, and
// every pixel or column update is a read-modify-write of one word, so one
// item is handled at a time. Clear, no operation and rejected commands go
// straight to the result; pixel and read each visit one word; frame and
// bar visit one word per column covered; a line first divides for the
// slope, then steps, skipping steps off the frame and writing those on it. The
// frame is empty after reset with no clearing pass: per-column valid bits
// make an unwritten column read as zero, and clear simply drops them.
// Each item gives exactly one result; read_data is zero for all but read.
// ----------------------------------------------------------------------------
module mono_framebuffer_draw_engine import mfde_pkg::*; #(
   parameter int FRAME_COLUMNS = 128,
   parameter int FRAME_ROWS    = 32
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_ready,
   input  wire logic [2:0]         req_command,
   input  wire logic [COORD_W-1:0] req_x_a,
   input  wire logic [COORD_W-1:0] req_y_a,
   input  wire logic [COORD_W-1:0] req_x_b,
   input  wire logic [COORD_W-1:0] req_y_b,
   input  wire logic               req_pixel_on,
   output logic                    rsp_valid,
   input  wire logic               rsp_ready,
   output logic [BYTE_W-1:0]       rsp_read_data
);

   localparam int CW     = $clog2(FRAME_COLUMNS);
   localparam int RW     = $clog2(FRAME_ROWS);
   localparam int NPAGES = (FRAME_ROWS + 7) / 8;
   localparam int PW     = (NPAGES > 1) ? $clog2(NPAGES) : 1;
   localparam int PIX_W  = ACC_W - FRAC_W;

   state_type state_ff, state_in;

   cmd_type                 cmd_ff;
   logic                    on_ff;
   logic [CW-1:0]           col_ff;
   logic [CW-1:0]           last_ff;
   logic [FRAME_ROWS-1:0]   mask_ff;
   logic [COORD_W-1:0]      xa_ff, xb_ff, ya_ff, yb_ff;
   logic [PW-1:0]           page_ff;
   logic [BYTE_W-1:0]       data_ff;
   logic                    rsp_valid_ff;
   logic [BYTE_W-1:0]       rsp_data_ff;
   logic signed [MAJ_W-1:0] pmaj_ff;
   logic signed [ACC_W-1:0] acc_ff;
   logic [COORD_W-1:0]      rem_ff;
   logic                    xmaj_ff, majneg_ff, minneg_ff;
   logic [SLOPE_W-1:0]      slope_ff;
   logic [FRAME_COLUMNS-1:0] valid_ff;
   logic [FRAME_ROWS-1:0]   frame_mem_ff [FRAME_COLUMNS];
   logic [FRAME_ROWS-1:0]   rd_ff;
   logic                    rdv_ff;

   cmd_type                 req_cmd;
   logic                    req_fire;
   logic                    col_ok, row_ok, page_ok, box_ok;
   logic signed [COORD_W:0] dx, dy;
   logic [COORD_W-1:0]      ax, ay, major, minor, start_min, start_maj;
   logic                    xmaj;
   logic                    div_start, div_done;
   logic [SLOPE_W-1:0]      div_slope;
   logic                    mem_we, out_free;
   logic [FRAME_ROWS-1:0]   old_word, box_mask, use_mask, wdata;
   logic [NPAGES*8-1:0]     ext_word;
   logic [BYTE_W-1:0]       page_byte;
   logic [PIX_W-1:0]        min_c, maj_c, col_c, row_c;
   logic                    step_ok;
   logic [COORD_W-1:0]      col9;

   assign req_cmd  = cmd_type'(req_command);
   assign req_fire = req_valid && req_ready;
   assign out_free = !rsp_valid_ff || rsp_ready;

   // request decode: range checks and line set-up
   always_comb begin
      col_ok  = !req_x_a[COORD_W-1]
                && ({1'b0, req_x_a} < (COORD_W+1)'(FRAME_COLUMNS));
      row_ok  = !req_y_a[COORD_W-1]
                && ({1'b0, req_y_a} < (COORD_W+1)'(FRAME_ROWS));
      page_ok = !req_y_a[COORD_W-1]
                && ({1'b0, req_y_a} < (COORD_W+1)'(NPAGES));
      box_ok  = !req_x_a[COORD_W-1] && !req_y_a[COORD_W-1]
                && !req_x_b[COORD_W-1] && !req_y_b[COORD_W-1]
                && (req_x_a <= req_x_b) && (req_y_a <= req_y_b) && col_ok;
      dx = $signed({req_x_b[COORD_W-1], req_x_b}) - $signed({req_x_a[COORD_W-1], req_x_a});
      dy = $signed({req_y_b[COORD_W-1], req_y_b}) - $signed({req_y_a[COORD_W-1], req_y_a});
      ax = dx[COORD_W] ? COORD_W'(-dx) : dx[COORD_W-1:0];
      ay = dy[COORD_W] ? COORD_W'(-dy) : dy[COORD_W-1:0];
      xmaj      = (ax >= ay);
      major     = xmaj ? ax : ay;
      minor     = xmaj ? ay : ax;
      start_maj = xmaj ? req_x_a : req_y_a;
      start_min = xmaj ? req_y_a : req_x_a;
   end

   // current line step: pixel position and range check
   always_comb begin
      min_c   = acc_ff[ACC_W-1:FRAC_W];
      maj_c   = PIX_W'(pmaj_ff);
      col_c   = xmaj_ff ? maj_c : min_c;
      row_c   = xmaj_ff ? min_c : maj_c;
      step_ok = !col_c[PIX_W-1] && (col_c < PIX_W'(FRAME_COLUMNS))
                && !row_c[PIX_W-1] && (row_c < PIX_W'(FRAME_ROWS));
   end

   // column mask for frame and bar
   always_comb begin
      col9 = COORD_W'(col_ff);
      for (int i = 0; i < FRAME_ROWS; i++) begin
         if (cmd_ff == CMD_BAR || col9 == xa_ff || col9 == xb_ff) begin
            box_mask[i] = (COORD_W'(i) >= ya_ff) && (COORD_W'(i) <= yb_ff);
         end else begin
            box_mask[i] = (COORD_W'(i) == ya_ff) || (COORD_W'(i) == yb_ff);
         end
      end
   end

   // modify stage
   always_comb begin
      old_word  = rdv_ff ? rd_ff : '0;
      use_mask  = (cmd_ff == CMD_FRAME || cmd_ff == CMD_BAR) ? box_mask : mask_ff;
      wdata     = on_ff ? (old_word | use_mask) : (old_word & ~use_mask);
      ext_word  = (NPAGES*8)'(old_word);
      page_byte = ext_word[page_ff*8 +: 8];
   end

   mfde_div u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .minor (minor),
      .major (major),
      .done  (div_done),
      .slope (div_slope)
   );

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               case (req_cmd)
                  CMD_PIXEL: state_in = (col_ok && row_ok) ? ST_RD : ST_FIN;
                  CMD_LINE:  state_in = (major == '0) ? ST_FIN : ST_DIV;
                  CMD_FRAME: state_in = box_ok ? ST_RD : ST_FIN;
                  CMD_BAR:   state_in = box_ok ? ST_RD : ST_FIN;
                  CMD_READ:  state_in = (col_ok && page_ok) ? ST_RD : ST_FIN;
                  default:   state_in = ST_FIN;
               endcase
            end
         end
         ST_DIV:   state_in = div_done ? ST_LSTEP : ST_DIV;
         ST_LSTEP: begin
            if (rem_ff == '0) begin
               state_in = ST_FIN;
            end else if (step_ok) begin
               state_in = ST_RD;
            end
         end
         ST_RD:    state_in = ST_WR;
         ST_WR: begin
            case (cmd_ff)
               CMD_LINE:  state_in = ST_LSTEP;
               CMD_FRAME: state_in = (col_ff == last_ff) ? ST_FIN : ST_RD;
               CMD_BAR:   state_in = (col_ff == last_ff) ? ST_FIN : ST_RD;
               default:   state_in = ST_FIN;
            endcase
         end
         ST_FIN:   state_in = out_free ? ST_IDLE : ST_FIN;
         default:  state_in = ST_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      req_ready = (state_ff == ST_IDLE);
      mem_we    = (state_ff == ST_WR) && (cmd_ff != CMD_READ);
      div_start = req_fire && (req_cmd == CMD_LINE) && (major != '0);
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         valid_ff     <= '0;
      end else begin
         state_ff <= state_in;
         if (state_ff == ST_FIN && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (req_fire && req_cmd == CMD_CLEAR) begin
            valid_ff <= '0;
         end else if (mem_we) begin
            valid_ff[col_ff] <= 1'b1;
         end
      end
   end

   // column memory, registered read
   always_ff @(posedge clock) begin
      if (mem_we) begin
         frame_mem_ff[col_ff] <= wdata;
      end
      rd_ff  <= frame_mem_ff[col_ff];
      rdv_ff <= valid_ff[col_ff];
   end

   // item datapath
   always_ff @(posedge clock) begin
      if (state_ff == ST_FIN && out_free) begin
         rsp_data_ff <= data_ff;
      end
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               cmd_ff    <= req_cmd;
               xa_ff     <= req_x_a;
               xb_ff     <= req_x_b;
               ya_ff     <= req_y_a;
               yb_ff     <= req_y_b;
               on_ff     <= (req_cmd == CMD_FRAME || req_cmd == CMD_BAR) ? 1'b1
                                                                          : req_pixel_on;
               col_ff    <= req_x_a[CW-1:0];
               last_ff   <= ({1'b0, req_x_b} < (COORD_W+1)'(FRAME_COLUMNS))
                            ? req_x_b[CW-1:0] : CW'(FRAME_COLUMNS - 1);
               mask_ff   <= FRAME_ROWS'(1) << req_y_a[RW-1:0];
               page_ff   <= req_y_a[PW-1:0];
               data_ff   <= '0;
               xmaj_ff   <= xmaj;
               majneg_ff <= xmaj ? dx[COORD_W] : dy[COORD_W];
               minneg_ff <= xmaj ? dy[COORD_W] : dx[COORD_W];
               rem_ff    <= major;
               pmaj_ff   <= MAJ_W'($signed(start_maj));
               acc_ff    <= {{(ACC_W-FRAC_W-COORD_W){start_min[COORD_W-1]}},
                             start_min, {FRAC_W{1'b0}}};
            end
         end
         ST_DIV: begin
            if (div_done) begin
               slope_ff <= div_slope;
            end
         end
         ST_LSTEP: begin
            if (rem_ff != '0) begin
               col_ff  <= col_c[CW-1:0];
               mask_ff <= FRAME_ROWS'(1) << row_c[RW-1:0];
               rem_ff  <= rem_ff - 1'b1;
               pmaj_ff <= majneg_ff ? pmaj_ff - MAJ_W'(1) : pmaj_ff + MAJ_W'(1);
               acc_ff  <= minneg_ff ? acc_ff - $signed(ACC_W'(slope_ff))
                                    : acc_ff + $signed(ACC_W'(slope_ff));
            end
         end
         ST_WR: begin
            if (cmd_ff == CMD_READ) begin
               data_ff <= page_byte;
            end
            if ((cmd_ff == CMD_FRAME || cmd_ff == CMD_BAR) && col_ff != last_ff) begin
               col_ff <= col_ff + 1'b1;
            end
         end
         default: begin
         end
      endcase
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_read_data = rsp_data_ff;

endmodule
`default_nettype wire

// ===== hdl/mfde_div.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_div
// Restoring divider for the line slope, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module mfde_div import mfde_pkg::*; (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [COORD_W-1:0] minor,
   input  wire logic [COORD_W-1:0] major,
   output logic                    done,
   output logic [SLOPE_W-1:0]      slope
);

   localparam int CNT_W = $clog2(DIVN_W);

   logic [DIVN_W-1:0]  num_ff;
   logic [DIVN_W-1:0]  quo_ff;
   logic [COORD_W-1:0] rem_ff;
   logic [COORD_W-1:0] den_ff;
   logic [CNT_W-1:0]   cnt_ff;
   logic               run_ff;
   logic               done_ff;
   logic [COORD_W:0]   trial;
   logic               qbit;
   logic [COORD_W:0]   diff;

   // one trial subtraction per cycle
   always_comb begin
      trial = {rem_ff, num_ff[DIVN_W-1]};
      qbit  = (trial >= {1'b0, den_ff});
      diff  = trial - {1'b0, den_ff};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            run_ff <= 1'b1;
         end else if (run_ff && cnt_ff == CNT_W'(DIVN_W - 1)) begin
            run_ff  <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= {minor, {FRAC_W{1'b0}}};
         den_ff <= major;
         rem_ff <= '0;
         quo_ff <= '0;
         cnt_ff <= '0;
      end else if (run_ff) begin
         num_ff <= {num_ff[DIVN_W-2:0], 1'b0};
         rem_ff <= qbit ? diff[COORD_W-1:0] : trial[COORD_W-1:0];
         quo_ff <= {quo_ff[DIVN_W-2:0], qbit};
         cnt_ff <= cnt_ff + 1'b1;
      end
   end

   assign done  = done_ff;
   assign slope = quo_ff[SLOPE_W-1:0];

endmodule
`default_nettype wire

// ===== hdl/mfde_checker.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// mfde_checker
// Port-level checks on the draw engine, bound to the top level.
// ----------------------------------------------------------------------------
module mfde_checker import mfde_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire logic [BYTE_W-1:0] rsp_read_data
);

   // no result straight out of reset
   a_reset_quiet: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   // an accepted item drops ready in the cycle after it is taken
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> !req_ready)
      else $error("request ready right after an item was taken");

   // a waiting result is held
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> rsp_valid)
      else $error("result dropped before it was taken");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> $stable(rsp_read_data))
      else $error("result data changed while stalled");

endmodule

bind mono_framebuffer_draw_engine mfde_checker u_mfde_checker (
   .clock         (clock),
   .reset         (reset),
   .req_valid     (req_valid),
   .req_ready     (req_ready),
   .rsp_valid     (rsp_valid),
   .rsp_ready     (rsp_ready),
   .rsp_read_data (rsp_read_data)
);
`default_nettype wire
